@@ src/mhfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mhfs_pkg
// Types, character codes and helpers shared by the mail header field splitter.
// ----------------------------------------------------------------------------
package mhfs_pkg;

    localparam int MaxRes = 6;
    localparam int CntW   = 3;

    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChSp  = 8'h20;
    localparam logic [7:0] ChTab = 8'h09;

    typedef enum logic [1:0] {
        KIND_FIELD_BYTE = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_BODY_BYTE  = 2'd2,
        KIND_MSG_END    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        HOLD_NONE    = 2'd0,
        HOLD_CR      = 2'd1,
        HOLD_CRLF    = 2'd2,
        HOLD_CRLF_CR = 2'd3
    } t_hold;

    typedef struct packed {
        logic  in_body;
        t_hold hold;
        logic  has_bytes;
        logic  prev_cr;
    } t_state;

    localparam t_state StateReset = '{
        in_body:   1'b0,
        hold:      HOLD_NONE,
        has_bytes: 1'b0,
        prev_cr:   1'b0
    };

    typedef struct packed {
        logic [CntW-1:0]          cnt;
        logic [MaxRes-1:0][1:0]   kind;
        logic [MaxRes-1:0][7:0]   data;
    } t_res_list;

    function automatic t_res_list push(t_res_list l, t_kind k, logic [7:0] b);
        t_res_list r;
        r = l;
        if (l.cnt < CntW'(MaxRes)) begin
            r.kind[l.cnt] = k;
            r.data[l.cnt] = b;
            r.cnt         = l.cnt + CntW'(1);
        end
        return r;
    endfunction

endpackage

@@ src/mhfs_decode.sv @@
// ----------------------------------------------------------------------------
// mhfs_decode
// Expands one raw byte into its list of result items and the next state.
// ----------------------------------------------------------------------------
module mhfs_decode (
    input  mhfs_pkg::t_state    i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_final,
    output mhfs_pkg::t_res_list o_list,
    output mhfs_pkg::t_state    o_state
);

    always_comb begin
        mhfs_pkg::t_res_list lst;
        mhfs_pkg::t_hold     hold;
        logic                body;
        logic                hb;
        logic [7:0]          c;

        lst  = '0;
        hold = i_state.hold;
        body = i_state.in_body;
        hb   = i_state.has_bytes;
        c    = i_byte;

        if (body) begin
            if (c == mhfs_pkg::ChLf && !i_state.prev_cr) begin
                lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_BODY_BYTE, mhfs_pkg::ChCr);
            end
            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_BODY_BYTE, c);
        end else begin
            case (hold)
                mhfs_pkg::HOLD_NONE: begin
                    if (c == mhfs_pkg::ChCr) begin
                        hold = mhfs_pkg::HOLD_CR;
                    end else if (c == mhfs_pkg::ChLf) begin
                        hold = mhfs_pkg::HOLD_CRLF;
                    end else begin
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE, c);
                        hb  = 1'b1;
                    end
                end
                mhfs_pkg::HOLD_CR: begin
                    if (c == mhfs_pkg::ChLf) begin
                        hold = mhfs_pkg::HOLD_CRLF;
                    end else begin
                        hold = mhfs_pkg::HOLD_NONE;
                        lst  = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                              mhfs_pkg::ChCr);
                        hb   = 1'b1;
                        if (c == mhfs_pkg::ChCr) begin
                            hold = mhfs_pkg::HOLD_CR;
                        end else begin
                            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE, c);
                        end
                    end
                end
                mhfs_pkg::HOLD_CRLF: begin
                    if (c == mhfs_pkg::ChCr) begin
                        hold = mhfs_pkg::HOLD_CRLF_CR;
                    end else if (c == mhfs_pkg::ChLf) begin
                        if (hb) begin
                            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_END, 8'h00);
                        end
                        hb   = 1'b0;
                        hold = mhfs_pkg::HOLD_NONE;
                        body = 1'b1;
                    end else if (c == mhfs_pkg::ChSp || c == mhfs_pkg::ChTab) begin
                        // fold: line end stays inside the field
                        hold = mhfs_pkg::HOLD_NONE;
                        lst  = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                              mhfs_pkg::ChCr);
                        lst  = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                              mhfs_pkg::ChLf);
                        lst  = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE, c);
                        hb   = 1'b1;
                    end else begin
                        hold = mhfs_pkg::HOLD_NONE;
                        if (hb) begin
                            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_END, 8'h00);
                        end
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE, c);
                        hb  = 1'b1;
                    end
                end
                default: begin
                    if (hb) begin
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_END, 8'h00);
                    end
                    hb   = 1'b0;
                    hold = mhfs_pkg::HOLD_NONE;
                    if (c == mhfs_pkg::ChLf) begin
                        body = 1'b1;
                    end else begin
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                             mhfs_pkg::ChCr);
                        hb  = 1'b1;
                        if (c == mhfs_pkg::ChCr) begin
                            hold = mhfs_pkg::HOLD_CR;
                        end else begin
                            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE, c);
                        end
                    end
                end
            endcase
        end

        if (i_final) begin
            if (!body) begin
                case (hold)
                    mhfs_pkg::HOLD_CR: begin
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                             mhfs_pkg::ChCr);
                        hb  = 1'b1;
                    end
                    mhfs_pkg::HOLD_CRLF_CR: begin
                        if (hb) begin
                            lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_END, 8'h00);
                        end
                        lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_BYTE,
                                             mhfs_pkg::ChCr);
                        hb  = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (hb) begin
                    lst = mhfs_pkg::push(lst, mhfs_pkg::KIND_FIELD_END, 8'h00);
                end
            end
            lst     = mhfs_pkg::push(lst, mhfs_pkg::KIND_MSG_END, 8'h00);
            o_state = mhfs_pkg::StateReset;
        end else begin
            o_state.in_body   = body;
            o_state.hold      = hold;
            o_state.has_bytes = hb;
            o_state.prev_cr   = (c == mhfs_pkg::ChCr);
        end

        o_list = lst;
    end

endmodule

@@ src/mhfs_emit.sv @@
// ----------------------------------------------------------------------------
// mhfs_emit
// Steps through a decoded result list, one request per cycle while the
// receiver takes them, into the output register.
// ----------------------------------------------------------------------------
module mhfs_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_vld,
    input  mhfs_pkg::t_res_list i_list,
    output logic                o_consume,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_item_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last
);

    logic [mhfs_pkg::CntW-1:0] r_idx;
    logic                      r_o_vld;
    logic [1:0]                r_o_kind;
    logic [7:0]                r_o_byte;
    logic                      r_o_last;

    logic free;
    logic is_last;
    logic empty;
    logic load;

    assign free      = !r_o_vld || i_ready;
    assign empty     = (i_list.cnt == '0);
    assign is_last   = (r_idx == i_list.cnt - mhfs_pkg::CntW'(1));
    assign load      = i_item_vld && !empty && free;
    assign o_consume = i_item_vld && (empty || (free && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_o_vld <= 1'b1;
            r_idx   <= is_last ? '0 : r_idx + mhfs_pkg::CntW'(1);
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_kind <= i_list.kind[r_idx];
            r_o_byte <= i_list.data[r_idx];
            r_o_last <= is_last;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_item_kind = r_o_kind;
    assign o_out_byte  = r_o_byte;
    assign o_run_last  = r_o_last;

endmodule

@@ src/mail_header_field_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// mail_header_field_splitter_unit
// Unfolds and splits mail header fields from a raw byte stream, normalizes
// line ends and passes the body through.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | i_valid / o_ready  | i_raw_byte, i_final_byte
//   out     | output    | o_valid / i_ready  | o_item_kind, o_out_byte, o_run_last
//
// One byte per cycle while each byte gives at most one request and the receiver
// does not stall; a byte with N results holds the input register until all N
// are emitted (N at most 5). A byte passes the input register, the decode and the output register.
// Input register and output register part the two sides; the emit step
// sets the rate. Synchronous active-low reset clears all parsing state.
// ----------------------------------------------------------------------------
module mail_header_field_splitter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_raw_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_item_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_final;
    mhfs_pkg::t_state    r_state;
    mhfs_pkg::t_state    n_state;
    mhfs_pkg::t_res_list list;
    logic                consume;

    assign o_ready = !r_in_vld || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_state  <= mhfs_pkg::StateReset;
        end else begin
            if (consume) begin
                r_state <= n_state;
            end
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (consume) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte  <= i_raw_byte;
            r_in_final <= i_final_byte;
        end
    end

    mhfs_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .o_list  (list),
        .o_state (n_state)
    );

    mhfs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (r_in_vld),
        .i_list      (list),
        .o_consume   (consume),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item_kind (o_item_kind),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

@@ src/mhfs_checker.sv @@
// ----------------------------------------------------------------------------
// mhfs_checker
// Port-level checks for the mail header field splitter.
// ----------------------------------------------------------------------------
module mhfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_raw_byte,
    input logic       i_final_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_item_kind,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item_kind)
            && $stable(o_out_byte) && $stable(o_run_last))
        else $error("result request changed while stalled");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == mhfs_pkg::KIND_FIELD_END
            || o_item_kind == mhfs_pkg::KIND_MSG_END) |-> o_out_byte == 8'h00)
        else $error("marker carries nonzero byte");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind == mhfs_pkg::KIND_MSG_END |-> o_run_last)
        else $error("message end not last of its run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind mail_header_field_splitter_unit mhfs_checker u_mhfs_checker (.*);

@@ tb/mhfs_split_checker.sv @@
// ----------------------------------------------------------------------------
// mhfs_split_checker
// Watches both channels of the mail header field splitter. Each input request
// is run through a behavioral model of the header unfolder; the results it
// predicts are queued and compared field by field against output requests.
// ----------------------------------------------------------------------------
module mhfs_split_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_raw_byte,
    input  logic       i_final_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_item_kind,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        mhfs_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
    } t_split_item;

    t_split_item split_q[$];
    t_split_item staged[mhfs_pkg::MaxRes];
    int          staged_n;
    t_split_item want;

    logic            body_mode;
    mhfs_pkg::t_hold held;
    logic            field_live;
    logic            saw_cr;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 30)
            $display("ERROR %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic void clear_parse();
        body_mode  = 1'b0;
        held       = mhfs_pkg::HOLD_NONE;
        field_live = 1'b0;
        saw_cr     = 1'b0;
    endfunction

    function automatic void stage(input mhfs_pkg::t_kind k, input logic [7:0] b);
        if (staged_n < mhfs_pkg::MaxRes) begin
            staged[staged_n] = '{kind: k, data: b, last: 1'b0};
            staged_n++;
        end
    endfunction

    function automatic void field_out(input logic [7:0] b);
        stage(mhfs_pkg::KIND_FIELD_BYTE, b);
        field_live = 1'b1;
    endfunction

    function automatic void end_field();
        if (field_live)
            stage(mhfs_pkg::KIND_FIELD_END, 8'h00);
        field_live = 1'b0;
    endfunction

    function automatic void plain_step(input logic [7:0] c);
        if (c == mhfs_pkg::ChCr)
            held = mhfs_pkg::HOLD_CR;
        else if (c == mhfs_pkg::ChLf)
            held = mhfs_pkg::HOLD_CRLF;
        else
            field_out(c);
    endfunction

    function automatic void open_body();
        end_field();
        held      = mhfs_pkg::HOLD_NONE;
        body_mode = 1'b1;
    endfunction

    function automatic void header_step(input logic [7:0] c);
        case (held)
            mhfs_pkg::HOLD_NONE: plain_step(c);
            mhfs_pkg::HOLD_CR: begin
                if (c == mhfs_pkg::ChLf) begin
                    held = mhfs_pkg::HOLD_CRLF;
                end else begin
                    held = mhfs_pkg::HOLD_NONE;
                    field_out(mhfs_pkg::ChCr);
                    plain_step(c);
                end
            end
            mhfs_pkg::HOLD_CRLF: begin
                if (c == mhfs_pkg::ChCr) begin
                    held = mhfs_pkg::HOLD_CRLF_CR;
                end else if (c == mhfs_pkg::ChLf) begin
                    open_body();
                end else if (c == mhfs_pkg::ChSp || c == mhfs_pkg::ChTab) begin
                    // folded line: the CRLF stays in the field
                    held = mhfs_pkg::HOLD_NONE;
                    field_out(mhfs_pkg::ChCr);
                    field_out(mhfs_pkg::ChLf);
                    field_out(c);
                end else begin
                    held = mhfs_pkg::HOLD_NONE;
                    end_field();
                    field_out(c);
                end
            end
            default: begin
                if (c == mhfs_pkg::ChLf) begin
                    open_body();
                end else begin
                    held = mhfs_pkg::HOLD_NONE;
                    end_field();
                    field_out(mhfs_pkg::ChCr);
                    plain_step(c);
                end
            end
        endcase
    endfunction

    function automatic void flush_held();
        case (held)
            mhfs_pkg::HOLD_CR: field_out(mhfs_pkg::ChCr);
            mhfs_pkg::HOLD_CRLF_CR: begin
                end_field();
                field_out(mhfs_pkg::ChCr);
            end
            default: ;
        endcase
        held = mhfs_pkg::HOLD_NONE;
        end_field();
    endfunction

    function automatic void predict_split(input logic [7:0] c, input logic last);
        staged_n = 0;
        if (body_mode) begin
            if (c == mhfs_pkg::ChLf && !saw_cr)
                stage(mhfs_pkg::KIND_BODY_BYTE, mhfs_pkg::ChCr);
            stage(mhfs_pkg::KIND_BODY_BYTE, c);
        end else begin
            header_step(c);
        end
        saw_cr = (c == mhfs_pkg::ChCr);
        if (last) begin
            if (!body_mode)
                flush_held();
            stage(mhfs_pkg::KIND_MSG_END, 8'h00);
            clear_parse();
        end
        if (staged_n > 0)
            staged[staged_n-1].last = 1'b1;
        for (int i = 0; i < staged_n; i++)
            split_q.push_back(staged[i]);
    endfunction

    task automatic check_result();
        if (split_q.size() == 0) begin
            report_mismatch($sformatf("result with none expected: kind %0d byte %02h last %0b",
                                      i_item_kind, i_out_byte, i_run_last));
        end else begin
            want = split_q.pop_front();
            o_checked++;
            if (i_item_kind !== want.kind)
                report_mismatch($sformatf("item_kind %0d, expected %0d",
                                          i_item_kind, want.kind));
            if (i_out_byte !== want.data)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          i_out_byte, want.data));
            if (i_run_last !== want.last)
                report_mismatch($sformatf("run_last %0b, expected %0b",
                                          i_run_last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            split_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_split(i_raw_byte, i_final_byte);
            if (i_out_valid && i_out_ready)
                check_result();
        end
        o_pending = split_q.size();
    end

endmodule

@@ tb/mail_header_field_splitter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// mail_header_field_splitter_unit_tb
// Feeds directed and random mail messages (well-formed headers with folds and
// bodies, truncated messages, control-byte noise) into the splitter with
// bursty requests and a patterned receiver; mhfs_split_checker scores results.
// ----------------------------------------------------------------------------
module mail_header_field_splitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LongHold = 200;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_CADENCE} t_rx_mode;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_raw_byte   = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_item_kind;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    int fail_count;
    int pending;
    int checked;

    logic rx_long_hold = 1'b0;
    logic rx_long_done = 1'b0;
    logic steady_send  = 1'b0;
    int   burst_left   = 0;
    int   bytes_sent   = 0;
    int   messages_sent = 0;
    logic [7:0] msg_q[$];

    mail_header_field_splitter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_byte   (i_raw_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item_kind  (o_item_kind),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

    mhfs_split_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_raw_byte   (i_raw_byte),
        .i_final_byte (i_final_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_item_kind  (o_item_kind),
        .i_out_byte   (o_out_byte),
        .i_run_last   (o_run_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall patterns, plus one long hold-off on request
    initial begin : rx_pattern
        t_rx_mode mode;
        int       rx_left;
        int       hold_cnt;
        int       tick;
        mode     = RX_OPEN;
        rx_left  = 0;
        hold_cnt = 0;
        tick     = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (rx_long_hold && !rx_long_done) begin
                i_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= LongHold)
                    rx_long_done = 1'b1;
            end else begin
                if (rx_left == 0) begin
                    mode    = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 80);
                end
                rx_left--;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_HALF:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        i_valid      <= 1'b1;
        i_raw_byte   <= b;
        i_final_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        if (burst_left > 0 || steady_send) begin
            if (burst_left > 0)
                burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        messages_sent++;
        msg_q.delete();
    endtask

    task automatic drain_pause();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic push_line_end();
        if ($urandom_range(0, 3) != 0)
            msg_q.push_back(mhfs_pkg::ChCr);
        msg_q.push_back(mhfs_pkg::ChLf);
    endtask

    task automatic push_value(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                msg_q.push_back(8'($urandom_range(0, 255)));
            else if (r == 1)
                msg_q.push_back(mhfs_pkg::ChSp);
            else
                msg_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    task automatic build_well_formed();
        int r;
        msg_q.delete();
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
            msg_q.push_back(8'h3A);
            msg_q.push_back(mhfs_pkg::ChSp);
            push_value($urandom_range(0, 4));
            if ($urandom_range(0, 2) == 0) begin
                push_line_end();
                msg_q.push_back($urandom_range(0, 1) ? mhfs_pkg::ChSp : mhfs_pkg::ChTab);
                push_value($urandom_range(1, 4));
            end
            push_line_end();
        end
        push_line_end();
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                msg_q.push_back(mhfs_pkg::ChCr);
            else if (r == 1)
                msg_q.push_back(mhfs_pkg::ChLf);
            else
                msg_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_noise();
        int r;
        msg_q.delete();
        repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 5);
            case (r)
                0:       msg_q.push_back(mhfs_pkg::ChCr);
                1:       msg_q.push_back(mhfs_pkg::ChLf);
                2:       msg_q.push_back(mhfs_pkg::ChSp);
                3:       msg_q.push_back(mhfs_pkg::ChTab);
                default: msg_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin : stimulus
        int start_bytes;
        int pick;
        int keep;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero byte, lone CR, bare LF fold, 0xFF, final in header
        msg_q = {8'h00, mhfs_pkg::ChCr, 8'h78, mhfs_pkg::ChLf, mhfs_pkg::ChSp, 8'hFF};
        send_message();
        // fold at message start, final byte leaves CR held
        msg_q = {mhfs_pkg::ChCr, mhfs_pkg::ChLf, mhfs_pkg::ChTab, mhfs_pkg::ChCr};
        send_message();
        // final byte leaves CRLF held
        msg_q = {8'h62, mhfs_pkg::ChLf};
        send_message();
        // empty first line then CR as final byte
        msg_q = {mhfs_pkg::ChLf, mhfs_pkg::ChCr};
        send_message();
        // CRLF CR LF opens the body; CRLF inside body
        msg_q = {8'h63, mhfs_pkg::ChCr, mhfs_pkg::ChLf, mhfs_pkg::ChCr, mhfs_pkg::ChLf,
                 mhfs_pkg::ChCr, mhfs_pkg::ChLf};
        send_message();
        // CRLF then CR before data, bare LF blank line, bare LF in body
        msg_q = {8'h64, mhfs_pkg::ChLf, mhfs_pkg::ChCr, 8'h65, mhfs_pkg::ChLf,
                 mhfs_pkg::ChLf, mhfs_pkg::ChLf};
        send_message();

        drain_pause();

        // long receiver hold-off while the sender keeps pushing
        rx_long_hold <= 1'b1;
        steady_send = 1'b1;
        repeat (2) begin
            build_well_formed();
            send_message();
        end
        steady_send = 1'b0;

        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < 100) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                build_well_formed();
            end else if (pick < 17) begin
                build_well_formed();
                keep = $urandom_range(1, msg_q.size());
                while (msg_q.size() > keep) void'(msg_q.pop_back());
            end else begin
                build_noise();
            end
            send_message();
            if ($urandom_range(0, 9) == 0)
                drain_pause();
        end

        drain_pause();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d messages, %0d bytes: folds, bare LFs, lone CRs, held line ends",
                 messages_sent, bytes_sent);
        $display("at the last byte, truncated headers and noise; %0d results compared.", checked);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
